/* hdl/lome_pkg.sv */
package lome_pkg;

  // Width of a slot index; the book holds at most 64 slots
  localparam int SLOT_W = 6;
  localparam int DEFAULT_BOOK_DEPTH = 32;
  localparam int MAX_FILLS = 32;
  localparam int FILL_CNT_W = 6;

  // Command broadcast from the controller to every slot cell
  typedef struct packed {
    logic              cancel;
    logic              fill;
    logic              write;
    logic              ask;
    logic [31:0]       limit;
    logic [31:0]       id;
    logic [31:0]       ts;
    logic [31:0]       qty;
    logic [SLOT_W-1:0] idx;
  } cmd_t;

  // Search state handed from one cell to the next
  typedef struct packed {
    logic              best_found;
    logic [SLOT_W-1:0] best_idx;
    logic [31:0]       best_price;
    logic [31:0]       best_time;
    logic [31:0]       best_qty;
    logic [31:0]       best_id;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
  } carry_t;

endpackage

/* hdl/lome_cell.sv */
module lome_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  lome_pkg::cmd_t    cmd,
  input  lome_pkg::carry_t  carry_in,
  output lome_pkg::carry_t  carry_out
);

  localparam logic [lome_pkg::SLOT_W-1:0] MY_IDX = lome_pkg::SLOT_W'(CELL_IDX);

  logic        valid;
  logic        side;
  logic [31:0] id;
  logic [31:0] ts;
  logic [31:0] price;
  logic [31:0] qty;

  logic             eligible;
  logic             better;
  lome_pkg::carry_t carry_next;

  // Update the slot from the broadcast command
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.write && cmd.idx == MY_IDX) begin
      valid <= 1'b1;
    end else if (cmd.cancel && valid && id == cmd.id) begin
      valid <= 1'b0;
    end else if (cmd.fill && cmd.idx == MY_IDX && qty == cmd.qty) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write && cmd.idx == MY_IDX) begin
      side  <= cmd.ask;
      id    <= cmd.id;
      ts    <= cmd.ts;
      price <= cmd.limit;
      qty   <= cmd.qty;
    end else if (cmd.fill && cmd.idx == MY_IDX) begin
      qty <= qty - cmd.qty;
    end
  end

  // Compare this slot against the best of the lower slots and find the first free slot
  always_comb begin
    eligible = valid && (side != cmd.ask) &&
               (cmd.ask ? (price >= cmd.limit) : (price <= cmd.limit));
    better = !carry_in.best_found ||
             (cmd.ask ? (price > carry_in.best_price) : (price < carry_in.best_price)) ||
             (price == carry_in.best_price && ts < carry_in.best_time);
    carry_next = carry_in;
    if (eligible && better) begin
      carry_next.best_found = 1'b1;
      carry_next.best_idx   = MY_IDX;
      carry_next.best_price = price;
      carry_next.best_time  = ts;
      carry_next.best_qty   = qty;
      carry_next.best_id    = id;
    end
    if (!carry_in.free_found && !valid) begin
      carry_next.free_found = 1'b1;
      carry_next.free_idx   = MY_IDX;
    end
  end

  // Hand the search result to the next cell
  always_ff @(posedge clk) begin
    carry_out <= carry_next;
  end

endmodule

/* hdl/limit_order_matching_engine.sv */
// Limit order book with price-time matching, one slot per cell.
// Request channel: order_tag, arrival_time, is_ask, limit_price and
// order_quantity are taken at a clock edge with start high and busy low.
// busy stays high until the final record of that request has been issued.
// Results: each record is on the result ports for one cycle, marked by
// result_valid. A request gives zero or more fill records (is_fill high)
// and then one final record (last high) with rested_quantity and book_full.
// Search: the best-match search is a wave along the chain of BOOK_DEPTH
// cells, one cell per cycle. Each fill takes a scan, a decide and an emit
// step (the product is formed in the emit step), and the final record
// follows the decide step after the last scan.
// Reset clears every slot's valid flag and returns the controller to idle.
// The receiver cannot stall: records are issued as they are produced.
module limit_order_matching_engine #(
  parameter int BOOK_DEPTH = lome_pkg::DEFAULT_BOOK_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] order_tag,
  input  logic [31:0] arrival_time,
  input  logic        is_ask,
  input  logic [31:0] limit_price,
  input  logic [31:0] order_quantity,
  output logic        result_valid,
  output logic        is_fill,
  output logic [31:0] buyer_id,
  output logic [31:0] seller_id,
  output logic [31:0] fill_price,
  output logic [31:0] fill_quantity,
  output logic [63:0] fill_value,
  output logic [31:0] rested_quantity,
  output logic        book_full,
  output logic        last
);

  typedef enum logic [4:0] {
    IDLE   = 5'b00001,
    CANCEL = 5'b00010,
    SCAN   = 5'b00100,
    DECIDE = 5'b01000,
    EMIT   = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [31:0] req_id;
  logic [31:0] req_ts;
  logic        req_ask;
  logic [31:0] req_limit;
  logic [31:0] left;
  logic [lome_pkg::FILL_CNT_W:0]   fill_cnt;
  logic [lome_pkg::SLOT_W-1:0]     scan_cnt;
  logic [31:0] fill_q;
  logic [31:0] fill_p;
  logic [31:0] fill_buyer;
  logic [31:0] fill_seller;

  lome_pkg::cmd_t   cmd;
  lome_pkg::carry_t carry [BOOK_DEPTH];
  lome_pkg::carry_t result;
  logic             do_fill;
  logic [31:0]      q_comb;

  assign busy   = (state != IDLE);
  assign result = carry[BOOK_DEPTH-1];

  // Chain of slot cells
  for (genvar i = 0; i < BOOK_DEPTH; i++) begin : g_cell
    lome_pkg::carry_t cin;
    if (i == 0) begin : g_head
      assign cin = '0;
    end else begin : g_link
      assign cin = carry[i-1];
    end
    lome_cell #(.CELL_IDX(i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .carry_in  (cin),
      .carry_out (carry[i])
    );
  end

  // Pick the fill or the free slot to write and build the broadcast command
  always_comb begin
    do_fill = (left != 32'd0) && result.best_found &&
              (fill_cnt < (lome_pkg::FILL_CNT_W+1)'(lome_pkg::MAX_FILLS));
    q_comb  = (result.best_qty < left) ? result.best_qty : left;
    cmd        = '0;
    cmd.ask    = req_ask;
    cmd.limit  = req_limit;
    cmd.id     = req_id;
    cmd.ts     = req_ts;
    cmd.cancel = (state == CANCEL);
    if (state == DECIDE) begin
      if (do_fill) begin
        cmd.fill = 1'b1;
        cmd.qty  = q_comb;
        cmd.idx  = result.best_idx;
      end else if (left != 32'd0 && result.free_found) begin
        cmd.write = 1'b1;
        cmd.qty   = left;
        cmd.idx   = result.free_idx;
      end
    end
  end

  // Advance the controller
  always_comb begin
    state_next = state;
    case (state)
      IDLE:    if (start) state_next = CANCEL;
      CANCEL:  state_next = SCAN;
      SCAN:    if (scan_cnt == lome_pkg::SLOT_W'(BOOK_DEPTH - 1)) state_next = DECIDE;
      DECIDE:  state_next = do_fill ? EMIT : IDLE;
      EMIT:    state_next = SCAN;
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= (state == EMIT) || (state == DECIDE && !do_fill);
    end
  end

  // Hold the request and the running counts
  always_ff @(posedge clk) begin
    if (state == SCAN) begin
      scan_cnt <= scan_cnt + 1'b1;
    end else begin
      scan_cnt <= '0;
    end
    case (state)
      IDLE: begin
        if (start) begin
          req_id    <= order_tag;
          req_ts    <= arrival_time;
          req_ask   <= is_ask;
          req_limit <= limit_price;
          left      <= order_quantity;
          fill_cnt  <= '0;
        end
      end
      DECIDE: begin
        if (do_fill) begin
          left        <= left - q_comb;
          fill_cnt    <= fill_cnt + 1'b1;
          fill_q      <= q_comb;
          fill_p      <= result.best_price;
          fill_buyer  <= req_ask ? result.best_id : req_id;
          fill_seller <= req_ask ? req_id : result.best_id;
        end
      end
      default: ;
    endcase
  end

  // Drive the result record
  always_ff @(posedge clk) begin
    if (state == EMIT) begin
      is_fill         <= 1'b1;
      buyer_id        <= fill_buyer;
      seller_id       <= fill_seller;
      fill_price      <= fill_p;
      fill_quantity   <= fill_q;
      fill_value      <= 64'(fill_q) * 64'(fill_p);
      rested_quantity <= '0;
      book_full       <= 1'b0;
      last            <= 1'b0;
    end else if (state == DECIDE && !do_fill) begin
      is_fill         <= 1'b0;
      buyer_id        <= '0;
      seller_id       <= '0;
      fill_price      <= '0;
      fill_quantity   <= '0;
      fill_value      <= '0;
      rested_quantity <= (left != 32'd0 && result.free_found) ? left : 32'd0;
      book_full       <= (left != 32'd0) && !result.free_found;
      last            <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");
  a_last_single: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last) |=> !result_valid)
    else $error("record issued right after final record");
  a_fill_not_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && is_fill) |-> (!last && busy))
    else $error("fill record marked last or issued while idle");
  a_final_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last) |-> !busy)
    else $error("final record issued while still busy");
`endif

endmodule

/* verif/tb_limit_order_matching_engine.sv */
`timescale 1ns / 1ps

module tb_limit_order_matching_engine;

  localparam int DEPTH = lome_pkg::DEFAULT_BOOK_DEPTH;
  localparam int FILL_CAP = lome_pkg::MAX_FILLS;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [31:0] id;
    logic [31:0] ts;
    logic        ask;
    logic [31:0] price;
    logic [31:0] qty;
  } order_t;

  typedef struct {
    logic        fill;
    logic [31:0] buyer;
    logic [31:0] seller;
    logic [31:0] price;
    logic [31:0] qty;
    logic [63:0] value;
    logic [31:0] rested;
    logic        full;
    logic        last;
  } record_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [31:0] order_tag;
  logic [31:0] arrival_time;
  logic        is_ask;
  logic [31:0] limit_price;
  logic [31:0] order_quantity;
  logic        result_valid;
  logic        is_fill;
  logic [31:0] buyer_id;
  logic [31:0] seller_id;
  logic [31:0] fill_price;
  logic [31:0] fill_quantity;
  logic [63:0] fill_value;
  logic [31:0] rested_quantity;
  logic        book_full;
  logic        last;

  // Book shadow kept by the predictor
  logic        bk_valid [DEPTH];
  logic        bk_ask   [DEPTH];
  logic [31:0] bk_id    [DEPTH];
  logic [31:0] bk_ts    [DEPTH];
  logic [31:0] bk_price [DEPTH];
  logic [31:0] bk_qty   [DEPTH];

  order_t  pending_orders[$];
  record_t expected_trades[$];
  int      errors;
  longint  cycles;
  bit      stim_done;
  bit      hold_for_drain;
  bit      quiet_phase;
  logic [31:0] ts_next;

  limit_order_matching_engine dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .order_tag(order_tag), .arrival_time(arrival_time), .is_ask(is_ask),
    .limit_price(limit_price), .order_quantity(order_quantity),
    .result_valid(result_valid), .is_fill(is_fill), .buyer_id(buyer_id),
    .seller_id(seller_id), .fill_price(fill_price), .fill_quantity(fill_quantity),
    .fill_value(fill_value), .rested_quantity(rested_quantity),
    .book_full(book_full), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Find best crossing resting order on the opposite side, -1 if none
  function automatic int best_resting(logic ask, logic [31:0] lim);
    int best;
    logic crosses;
    logic better;
    best = -1;
    for (int s = 0; s < DEPTH; s++) begin
      if (bk_valid[s] && bk_ask[s] != ask) begin
        crosses = ask ? (bk_price[s] >= lim) : (bk_price[s] <= lim);
        if (crosses) begin
          if (best < 0) begin
            best = s;
          end else begin
            better = ask ? (bk_price[s] > bk_price[best]) : (bk_price[s] < bk_price[best]);
            if (better || (bk_price[s] == bk_price[best] && bk_ts[s] < bk_ts[best]))
              best = s;
          end
        end
      end
    end
    return best;
  endfunction

  // Apply one request to the shadow book and queue the records it yields
  task automatic predict_trades(order_t o);
    logic [31:0] left;
    logic [31:0] q;
    int n;
    int m;
    int free_slot;
    record_t r;
    left = o.qty;
    n = 0;
    for (int s = 0; s < DEPTH; s++)
      if (bk_valid[s] && bk_id[s] == o.id) bk_valid[s] = 1'b0;
    while (left != 0 && n < FILL_CAP) begin
      m = best_resting(o.ask, o.price);
      if (m < 0) break;
      q = (bk_qty[m] < left) ? bk_qty[m] : left;
      r = '{default: '0};
      r.fill = 1'b1;
      r.buyer = o.ask ? bk_id[m] : o.id;
      r.seller = o.ask ? o.id : bk_id[m];
      r.price = bk_price[m];
      r.qty = q;
      r.value = 64'(q) * 64'(bk_price[m]);
      expected_trades.push_back(r);
      n++;
      left -= q;
      bk_qty[m] -= q;
      if (bk_qty[m] == 0) bk_valid[m] = 1'b0;
    end
    r = '{default: '0};
    r.last = 1'b1;
    if (left != 0) begin
      free_slot = -1;
      for (int s = 0; s < DEPTH; s++)
        if (!bk_valid[s] && free_slot < 0) free_slot = s;
      if (free_slot < 0) begin
        r.full = 1'b1;
      end else begin
        bk_valid[free_slot] = 1'b1;
        bk_ask[free_slot] = o.ask;
        bk_id[free_slot] = o.id;
        bk_ts[free_slot] = o.ts;
        bk_price[free_slot] = o.price;
        bk_qty[free_slot] = left;
        r.rested = left;
      end
    end
    expected_trades.push_back(r);
  endtask

  task automatic add_order(logic [31:0] id, logic [31:0] ts, logic ask,
                           logic [31:0] price, logic [31:0] qty);
    order_t o;
    o.id = id;
    o.ts = ts;
    o.ask = ask;
    o.price = price;
    o.qty = qty;
    pending_orders.push_back(o);
  endtask

  // Random order near a mid price so that most requests cross or rest nearby
  task automatic add_random_order();
    logic [31:0] id;
    logic [31:0] price;
    logic [31:0] qty;
    int pick;
    pick = $urandom_range(0, 99);
    id = (pick < 85) ? 32'($urandom_range(1, 40)) : $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 80) price = 32'($urandom_range(990, 1010));
    else if (pick < 90) price = $urandom;
    else price = (pick < 95) ? 32'h0 : 32'hFFFF_FFFF;
    pick = $urandom_range(0, 99);
    if (pick < 75) qty = 32'($urandom_range(1, 50));
    else if (pick < 85) qty = 32'h0;
    else qty = $urandom;
    ts_next += 32'($urandom_range(1, 3));
    add_order(id, ts_next, 1'($urandom), price, qty);
  endtask

  // Fill the request queue: directed cases first, then random traffic
  initial begin
    ts_next = 32'd100;
    // same time stamps: lower slot wins; trade at resting price
    add_order(32'd1, 32'd5, 1'b1, 32'd100, 32'd10);
    add_order(32'd2, 32'd5, 1'b1, 32'd100, 32'd10);
    add_order(32'd3, 32'd4, 1'b1, 32'd99, 32'd3);
    add_order(32'd4, 32'd6, 1'b0, 32'd100, 32'd15);
    // replace, then cancel with zero quantity
    add_order(32'd2, 32'd7, 1'b1, 32'd120, 32'd8);
    add_order(32'd2, 32'd8, 1'b1, 32'd120, 32'd0);
    add_order(32'd9, 32'd9, 1'b0, 32'd0, 32'd0);
    // extreme fields and the widest product
    add_order(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_order(32'h0, 32'h0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_order(32'h5, 32'h10, 1'b1, 32'h0, 32'd7);
    add_order(32'h6, 32'h11, 1'b0, 32'h0, 32'd7);
    // full book: fill every slot with bids that do not cross, then overflow
    for (int i = 0; i < DEPTH + 2; i++)
      add_order(32'd1000 + i, 32'd20 + i, 1'b0, 32'd10 + i, 32'd1);
    // sweep many levels in one request
    add_order(32'd2000, 32'd60, 1'b1, 32'd0, 32'd40);
    for (int i = 0; i < 160; i++) add_random_order();
  end

  // Drive requests; pause at random and once until all records are back
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      cycles <= 0;
    end else begin
      cycles <= cycles + 1;
      if (start && !busy) begin
        predict_trades(pending_orders.pop_front());
      end
      if (start && busy) begin
        // hold the current request until it is taken
      end else if (pending_orders.size() == 0 || hold_for_drain ||
                   (!quiet_phase && $urandom_range(0, 99) < 24)) begin
        start <= 1'b0;
        if (pending_orders.size() == 0 && !(start && busy)) stim_done <= 1'b1;
      end else begin
        order_tag <= pending_orders[0].id;
        arrival_time <= pending_orders[0].ts;
        is_ask <= pending_orders[0].ask;
        limit_price <= pending_orders[0].price;
        order_quantity <= pending_orders[0].qty;
        start <= 1'b1;
      end
    end
  end

  // Check each issued record against the oldest expectation
  always @(posedge clk) begin
    record_t e;
    if (!rst && result_valid) begin
      if (expected_trades.size() == 0) begin
        $error("unexpected record: is_fill=%0b last=%0b", is_fill, last);
        errors++;
      end else begin
        e = expected_trades.pop_front();
        if (is_fill !== e.fill) begin
          $error("is_fill: expected %0h got %0h", e.fill, is_fill); errors++;
        end
        if (buyer_id !== e.buyer) begin
          $error("buyer_id: expected %0h got %0h", e.buyer, buyer_id); errors++;
        end
        if (seller_id !== e.seller) begin
          $error("seller_id: expected %0h got %0h", e.seller, seller_id); errors++;
        end
        if (fill_price !== e.price) begin
          $error("fill_price: expected %0h got %0h", e.price, fill_price); errors++;
        end
        if (fill_quantity !== e.qty) begin
          $error("fill_quantity: expected %0h got %0h", e.qty, fill_quantity); errors++;
        end
        if (fill_value !== e.value) begin
          $error("fill_value: expected %0h got %0h", e.value, fill_value); errors++;
        end
        if (rested_quantity !== e.rested) begin
          $error("rested_quantity: expected %0h got %0h", e.rested, rested_quantity);
          errors++;
        end
        if (book_full !== e.full) begin
          $error("book_full: expected %0h got %0h", e.full, book_full); errors++;
        end
        if (last !== e.last) begin
          $error("last: expected %0h got %0h", e.last, last); errors++;
        end
      end
    end
  end

  // Reset, shape the idling phases, then wait for the drain
  initial begin
    errors = 0;
    stim_done = 1'b0;
    hold_for_drain = 1'b0;
    quiet_phase = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    order_tag = '0;
    arrival_time = '0;
    is_ask = 1'b0;
    limit_price = '0;
    order_quantity = '0;
    for (int i = 0; i < DEPTH; i++) bk_valid[i] = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    fork
      begin
        // hold off after the directed part until the book settles
        wait (pending_orders.size() <= 160);
        @(posedge clk);
        hold_for_drain = 1'b1;
        wait (expected_trades.size() == 0 && !busy);
        @(posedge clk);
        hold_for_drain = 1'b0;
        wait (pending_orders.size() <= 100);
        quiet_phase = 1'b1;
        wait (pending_orders.size() <= 60);
        quiet_phase = 1'b0;
        wait (stim_done && expected_trades.size() == 0);
        repeat (2 * DEPTH + 10) @(posedge clk);
      end
      wait (cycles >= CYCLE_LIMIT);
    join_any
    if (cycles >= CYCLE_LIMIT) begin
      $display("limit_order_matching_engine: mismatch");
    end else if (errors == 0 && expected_trades.size() == 0) begin
      $display("limit_order_matching_engine: match");
    end else begin
      $display("limit_order_matching_engine: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/lome_pkg.sv
hdl/lome_cell.sv
hdl/limit_order_matching_engine.sv
verif/tb_limit_order_matching_engine.sv
